@@ rtl/core/frame_deframer_crc16_check_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the frame deframer
// Shared immediate-cycle and next-cycle implication checks, clocked on aclk
// and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef FRAME_DEFRAMER_CRC16_CHECK_ASSERT_SVH
`define FRAME_DEFRAMER_CRC16_CHECK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fdc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fdc: next-cycle check failed");

`endif

@@ rtl/core/fdc_pkg.sv @@
// ----------------------------------------------------------------------------
// Frame deframer package
// Types, register indexes, reset values and the byte-wise CRC-16 update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fdc_pkg;

    localparam int COUNTER_BITS_DEF = 32;
    localparam int COUNT_OUT_W      = 32;

    localparam logic [7:0]  MARK_FIRST_RST = 8'hA5;
    localparam logic [7:0]  MARK_SECOND_RST = 8'h5A;
    localparam logic [15:0] MAX_LEN_RST    = 16'd512;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'h1021;

    localparam logic [1:0] CFG_MARK_FIRST  = 2'd0;
    localparam logic [1:0] CFG_MARK_SECOND = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN     = 2'd2;

    typedef enum logic [3:0] {
        PH_HUNT0   = 4'd0,
        PH_HUNT1   = 4'd1,
        PH_VER     = 4'd2,
        PH_TYPE    = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_SEQ     = 4'd6,
        PH_PAYLOAD = 4'd7,
        PH_CRC_LO  = 4'd8,
        PH_CRC_HI  = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        EV_PAYLOAD  = 2'd0,
        EV_GOOD     = 2'd1,
        EV_BAD_CRC  = 2'd2,
        EV_OVER_LEN = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                    event_kind;
        logic [7:0]               payload_byte;
        logic [15:0]              payload_index;
        logic [7:0]               frame_version;
        logic [7:0]               frame_type;
        logic [7:0]               frame_sequence;
        logic [15:0]              frame_length;
        logic [15:0]              received_crc;
        logic [COUNT_OUT_W-1:0]   good_frame_count;
        logic [COUNT_OUT_W-1:0]   bad_frame_count;
    } result_t;

    // CRC-16-CCITT, MSB first, one byte per call.
    function automatic logic [15:0] fdc_crc_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/frame_deframer_crc16_check.sv @@
// A result item appears on the m_ side in the cycle after the byte that causes it is accepted.
// Throughput: one received byte per cycle while the input does not stall, set by the parser step.
// The input stalls only while a result waits in the output register and m_ready is low.
// Reset (aresetn low, synchronous): parser hunts, CRC is FFFF, counters clear,
// and the configuration registers return to A5, 5A and 512.
// ----------------------------------------------------------------------------
// Frame deframer with CRC-16 check
// Receives link bytes, parses start mark, header, payload and CRC trailer,
// and reports payload bytes and frame status items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frame_deframer_crc16_check
    import fdc_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_event_kind,
    output logic [7:0]       m_payload_byte,
    output logic [15:0]      m_payload_index,
    output logic [7:0]       m_frame_version,
    output logic [7:0]       m_frame_type,
    output logic [7:0]       m_frame_sequence,
    output logic [15:0]      m_frame_length,
    output logic [15:0]      m_received_crc,
    output logic [31:0]      m_good_frame_count,
    output logic [31:0]      m_bad_frame_count,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic    accept;
    logic    can_take;
    logic    res_valid;
    result_t res;
    result_t res_q;

    assign s_ready   = can_take;
    assign accept    = s_valid && can_take;
    assign cfg_ready = 1'b1;

    fdc_parser #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (accept),
        .rx_byte   (s_rx_byte),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    fdc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (accept),
        .res_valid (res_valid),
        .res       (res),
        .m_ready   (m_ready),
        .can_take  (can_take),
        .m_valid   (m_valid),
        .res_q     (res_q)
    );

    assign m_event_kind       = res_q.event_kind;
    assign m_payload_byte     = res_q.payload_byte;
    assign m_payload_index    = res_q.payload_index;
    assign m_frame_version    = res_q.frame_version;
    assign m_frame_type       = res_q.frame_type;
    assign m_frame_sequence   = res_q.frame_sequence;
    assign m_frame_length     = res_q.frame_length;
    assign m_received_crc     = res_q.received_crc;
    assign m_good_frame_count = res_q.good_frame_count;
    assign m_bad_frame_count  = res_q.bad_frame_count;

endmodule

`default_nettype wire

@@ rtl/core/fdc_parser.sv @@
// ----------------------------------------------------------------------------
// Frame parser
// Walks the frame header, payload and trailer one byte per item, keeps the
// running CRC and the frame counters, and forms at most one result per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "frame_deframer_crc16_check_assert.svh"

module fdc_parser
    import fdc_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             res_valid,
    output result_t          res
);

    phase_t                  phase_reg, phase_next;
    logic [7:0]              version_reg, version_next;
    logic [7:0]              type_reg, type_next;
    logic [15:0]             length_reg, length_next;
    logic [7:0]              sequence_reg, sequence_next;
    logic [15:0]             position_reg, position_next;
    logic [15:0]             crc_reg, crc_next;
    logic [7:0]              crc_low_reg, crc_low_next;
    logic [COUNTER_BITS-1:0] good_reg, good_next;
    logic [COUNTER_BITS-1:0] bad_reg, bad_next;
    logic [7:0]              mark_first_reg;
    logic [7:0]              mark_second_reg;
    logic [15:0]             max_len_reg;

    logic [15:0]             crc_step;
    logic [15:0]             length_full;
    logic [15:0]             position_inc;
    logic [15:0]             wire_crc;
    logic [COUNT_OUT_W-1:0]  good_out;
    logic [COUNT_OUT_W-1:0]  bad_out;

    assign crc_step     = fdc_crc_byte(crc_reg, rx_byte);
    assign length_full  = {rx_byte, length_reg[7:0]};
    assign position_inc = position_reg + 16'd1;
    assign wire_crc     = {rx_byte, crc_low_reg};

    generate
        if (COUNTER_BITS >= COUNT_OUT_W) begin : g_cnt_wide
            assign good_out = good_next[COUNT_OUT_W-1:0];
            assign bad_out  = bad_next[COUNT_OUT_W-1:0];
        end else begin : g_cnt_narrow
            assign good_out = {{(COUNT_OUT_W-COUNTER_BITS){1'b0}}, good_next};
            assign bad_out  = {{(COUNT_OUT_W-COUNTER_BITS){1'b0}}, bad_next};
        end
    endgenerate

    always_comb begin
        phase_next = phase_reg;
        if (step) begin
            unique case (phase_reg)
                PH_HUNT0: begin
                    if (rx_byte == mark_first_reg) begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_HUNT1: begin
                    phase_next = (rx_byte == mark_second_reg) ? PH_VER : PH_HUNT0;
                end
                PH_VER:    phase_next = PH_TYPE;
                PH_TYPE:   phase_next = PH_LEN_LO;
                PH_LEN_LO: phase_next = PH_LEN_HI;
                PH_LEN_HI: begin
                    phase_next = (length_full > max_len_reg) ? PH_HUNT0 : PH_SEQ;
                end
                PH_SEQ: begin
                    phase_next = (length_reg == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (position_inc >= length_reg) begin
                        phase_next = PH_CRC_LO;
                    end
                end
                PH_CRC_LO: phase_next = PH_CRC_HI;
                PH_CRC_HI: phase_next = PH_HUNT0;
                default:   phase_next = PH_HUNT0;
            endcase
        end
    end

    always_comb begin
        version_next  = version_reg;
        type_next     = type_reg;
        length_next   = length_reg;
        sequence_next = sequence_reg;
        position_next = position_reg;
        crc_next      = crc_reg;
        crc_low_next  = crc_low_reg;
        good_next     = good_reg;
        bad_next      = bad_reg;
        res_valid     = 1'b0;
        res.event_kind       = EV_PAYLOAD;
        res.payload_byte     = 8'h00;
        res.payload_index    = 16'h0000;
        res.frame_version    = version_reg;
        res.frame_type       = type_reg;
        res.frame_sequence   = 8'h00;
        res.frame_length     = length_reg;
        res.received_crc     = 16'h0000;
        res.good_frame_count = good_out;
        res.bad_frame_count  = bad_out;
        if (step) begin
            unique case (phase_reg)
                PH_HUNT1: begin
                    if (rx_byte == mark_second_reg) begin
                        crc_next = CRC_INIT;
                    end
                end
                PH_VER: begin
                    version_next = rx_byte;
                    crc_next     = crc_step;
                end
                PH_TYPE: begin
                    type_next = rx_byte;
                    crc_next  = crc_step;
                end
                PH_LEN_LO: begin
                    length_next = {8'h00, rx_byte};
                    crc_next    = crc_step;
                end
                PH_LEN_HI: begin
                    length_next = length_full;
                    crc_next    = crc_step;
                    if (length_full > max_len_reg) begin
                        bad_next         = bad_reg + COUNTER_BITS'(1);
                        res_valid        = 1'b1;
                        res.event_kind   = EV_OVER_LEN;
                        res.frame_length = length_full;
                    end
                end
                PH_SEQ: begin
                    sequence_next = rx_byte;
                    crc_next      = crc_step;
                    position_next = 16'h0000;
                end
                PH_PAYLOAD: begin
                    crc_next           = crc_step;
                    position_next      = position_inc;
                    res_valid          = 1'b1;
                    res.event_kind     = EV_PAYLOAD;
                    res.payload_byte   = rx_byte;
                    res.payload_index  = position_reg;
                    res.frame_sequence = sequence_reg;
                end
                PH_CRC_LO: begin
                    crc_low_next = rx_byte;
                end
                PH_CRC_HI: begin
                    res_valid          = 1'b1;
                    res.frame_sequence = sequence_reg;
                    res.received_crc   = wire_crc;
                    if (wire_crc == crc_reg) begin
                        good_next      = good_reg + COUNTER_BITS'(1);
                        res.event_kind = EV_GOOD;
                    end else begin
                        bad_next       = bad_reg + COUNTER_BITS'(1);
                        res.event_kind = EV_BAD_CRC;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT0;
            version_reg  <= '0;
            type_reg     <= '0;
            length_reg   <= '0;
            sequence_reg <= '0;
            position_reg <= '0;
            crc_reg      <= CRC_INIT;
            crc_low_reg  <= '0;
            good_reg     <= '0;
            bad_reg      <= '0;
        end else begin
            phase_reg    <= phase_next;
            version_reg  <= version_next;
            type_reg     <= type_next;
            length_reg   <= length_next;
            sequence_reg <= sequence_next;
            position_reg <= position_next;
            crc_reg      <= crc_next;
            crc_low_reg  <= crc_low_next;
            good_reg     <= good_next;
            bad_reg      <= bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_first_reg  <= MARK_FIRST_RST;
            mark_second_reg <= MARK_SECOND_RST;
            max_len_reg     <= MAX_LEN_RST;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_MARK_FIRST:  mark_first_reg  <= cfg_data[7:0];
                CFG_MARK_SECOND: mark_second_reg <= cfg_data[7:0];
                CFG_MAX_LEN:     max_len_reg     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    `FDC_ASSERT_SAME(a_payload_emits, step && phase_reg == PH_PAYLOAD,
                     res_valid && res.event_kind == EV_PAYLOAD)
    `FDC_ASSERT_NEXT(a_trailer_rehunts, step && phase_reg == PH_CRC_HI,
                     phase_reg == PH_HUNT0)
    `FDC_ASSERT_SAME(a_position_bound, phase_reg == PH_PAYLOAD,
                     position_reg < length_reg)

endmodule

`default_nettype wire

@@ rtl/core/fdc_out_stage.sv @@
// ----------------------------------------------------------------------------
// Result register
// Holds one result item for the output channel and lets the input side keep
// moving while the register is empty or being drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdc_out_stage
    import fdc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     take,
    input  wire logic     res_valid,
    input  wire result_t  res,
    input  wire logic     m_ready,
    output logic          can_take,
    output logic          m_valid,
    output result_t       res_q
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign can_take = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign res_q    = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = res_valid;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && res_valid) begin
            data_reg <= res;
        end
    end

endmodule

`default_nettype wire

@@ sim/tb_frame_deframer_crc16_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the CRC-16 frame deframer
// Feeds directed and random link bytes into the deframer and mirrors its
// parser in a local model. Every payload byte and frame status item that
// comes out is checked against the model or a directed table entry. Both sides stall at random, and
// the register settings change between traffic phases.
// ----------------------------------------------------------------------------

module tb_frame_deframer_crc16_check;
    import fdc_pkg::*;

    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int         STALL_LIMIT = 2000;

    typedef enum logic [1:0] {
        ROW_LIT,
        ROW_CRC_LO,
        ROW_CRC_HI,
        ROW_CRC_HI_BAD
    } row_src_t;

    typedef enum logic [1:0] {
        FAULT_NONE,
        FAULT_CRC,
        FAULT_MARK,
        FAULT_CUT
    } frame_fault_t;

    typedef struct packed {
        row_src_t   src;
        logic [7:0] data;
        logic       typed;
        result_t    want;
    } dir_row_t;

    localparam dir_row_t DIRECTED [31] = '{
        '{ROW_LIT, 8'h00, 1'b0, '0},
        '{ROW_LIT, 8'hA5, 1'b0, '0},
        '{ROW_LIT, 8'h00, 1'b0, '0},
        '{ROW_LIT, 8'hA5, 1'b0, '0},
        '{ROW_LIT, 8'hA5, 1'b0, '0},
        '{ROW_LIT, 8'h5A, 1'b0, '0},
        '{ROW_LIT, 8'hA5, 1'b0, '0},
        '{ROW_LIT, 8'h5A, 1'b0, '0},
        '{ROW_LIT, 8'hFF, 1'b0, '0},
        '{ROW_LIT, 8'h00, 1'b0, '0},
        '{ROW_LIT, 8'h01, 1'b0, '0},
        '{ROW_LIT, 8'h02, 1'b1,
          '{EV_OVER_LEN, 8'h00, 16'h0000, 8'hFF, 8'h00, 8'h00, 16'd513, 16'h0000,
            32'd0, 32'd1}},
        '{ROW_LIT, 8'hA5, 1'b0, '0},
        '{ROW_LIT, 8'h5A, 1'b0, '0},
        '{ROW_LIT, 8'h01, 1'b0, '0},
        '{ROW_LIT, 8'h02, 1'b0, '0},
        '{ROW_LIT, 8'h00, 1'b0, '0},
        '{ROW_LIT, 8'h00, 1'b0, '0},
        '{ROW_LIT, 8'h03, 1'b0, '0},
        '{ROW_CRC_LO, 8'h00, 1'b0, '0},
        '{ROW_CRC_HI, 8'h00, 1'b0, '0},
        '{ROW_LIT, 8'hA5, 1'b0, '0},
        '{ROW_LIT, 8'h5A, 1'b0, '0},
        '{ROW_LIT, 8'h00, 1'b0, '0},
        '{ROW_LIT, 8'hFF, 1'b0, '0},
        '{ROW_LIT, 8'h01, 1'b0, '0},
        '{ROW_LIT, 8'h00, 1'b0, '0},
        '{ROW_LIT, 8'hFF, 1'b0, '0},
        '{ROW_LIT, 8'h00, 1'b1,
          '{EV_PAYLOAD, 8'h00, 16'h0000, 8'h00, 8'hFF, 8'hFF, 16'd1, 16'h0000,
            32'd1, 32'd1}},
        '{ROW_CRC_LO, 8'h00, 1'b0, '0},
        '{ROW_CRC_HI_BAD, 8'h00, 1'b0, '0}
    };

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte   = 8'h00;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [1:0]  m_event_kind;
    logic [7:0]  m_payload_byte;
    logic [15:0] m_payload_index;
    logic [7:0]  m_frame_version;
    logic [7:0]  m_frame_type;
    logic [7:0]  m_frame_sequence;
    logic [15:0] m_frame_length;
    logic [15:0] m_received_crc;
    logic [31:0] m_good_frame_count;
    logic [31:0] m_bad_frame_count;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index   = CFG_MARK_FIRST;
    logic [15:0] cfg_data    = 16'h0000;

    logic [7:0]  mark_a      = MARK_FIRST_RST;
    logic [7:0]  mark_b      = MARK_SECOND_RST;
    logic [15:0] len_limit   = MAX_LEN_RST;
    phase_t      parse_st    = PH_HUNT0;
    logic [7:0]  hold_ver    = 8'h00;
    logic [7:0]  hold_type   = 8'h00;
    logic [15:0] hold_len    = 16'h0000;
    logic [7:0]  hold_seq    = 8'h00;
    logic [15:0] pay_pos     = 16'h0000;
    logic [15:0] crc_acc     = CRC_INIT;
    logic [7:0]  crc_lo_hold = 8'h00;
    logic [31:0] good_cnt    = 32'd0;
    logic [31:0] bad_cnt     = 32'd0;

    result_t     event_q [$];
    result_t     head_event;
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int unsigned bytes_sent     = 0;
    int unsigned burst_left     = 0;

    frame_deframer_crc16_check i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_kind       (m_event_kind),
        .m_payload_byte     (m_payload_byte),
        .m_payload_index    (m_payload_index),
        .m_frame_version    (m_frame_version),
        .m_frame_type       (m_frame_type),
        .m_frame_sequence   (m_frame_sequence),
        .m_frame_length     (m_frame_length),
        .m_received_crc     (m_received_crc),
        .m_good_frame_count (m_good_frame_count),
        .m_bad_frame_count  (m_bad_frame_count),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [15:0] crc16_ccitt_next(input logic [15:0] acc,
                                                     input logic [7:0]  data);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ data[i];
            r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic void log_event(input kind_t kind, input logic [7:0] pbyte,
                                      input logic [15:0] pidx, input logic [7:0] seq,
                                      input logic [15:0] len, input logic [15:0] crc_wire);
        result_t ev;
        ev.event_kind       = kind;
        ev.payload_byte     = pbyte;
        ev.payload_index    = pidx;
        ev.frame_version    = hold_ver;
        ev.frame_type       = hold_type;
        ev.frame_sequence   = seq;
        ev.frame_length     = len;
        ev.received_crc     = crc_wire;
        ev.good_frame_count = good_cnt;
        ev.bad_frame_count  = bad_cnt;
        event_q.push_back(ev);
    endfunction

    function automatic void deframe_step(input logic [7:0] c);
        logic [15:0] wire_crc;
        case (parse_st)
            PH_HUNT0: begin
                if (c == mark_a) parse_st = PH_HUNT1;
            end
            PH_HUNT1: begin
                if (c == mark_b) begin
                    crc_acc  = CRC_INIT;
                    parse_st = PH_VER;
                end else begin
                    parse_st = PH_HUNT0;
                end
            end
            PH_VER: begin
                hold_ver = c;
                crc_acc  = crc16_ccitt_next(crc_acc, c);
                parse_st = PH_TYPE;
            end
            PH_TYPE: begin
                hold_type = c;
                crc_acc   = crc16_ccitt_next(crc_acc, c);
                parse_st  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                hold_len = {8'h00, c};
                crc_acc  = crc16_ccitt_next(crc_acc, c);
                parse_st = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                hold_len[15:8] = c;
                crc_acc        = crc16_ccitt_next(crc_acc, c);
                if (hold_len > len_limit) begin
                    bad_cnt  = bad_cnt + 32'd1;
                    parse_st = PH_HUNT0;
                    log_event(EV_OVER_LEN, 8'h00, 16'h0000, 8'h00, hold_len, 16'h0000);
                end else begin
                    parse_st = PH_SEQ;
                end
            end
            PH_SEQ: begin
                hold_seq = c;
                crc_acc  = crc16_ccitt_next(crc_acc, c);
                pay_pos  = 16'h0000;
                parse_st = (hold_len == 16'h0000) ? PH_CRC_LO : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                crc_acc = crc16_ccitt_next(crc_acc, c);
                log_event(EV_PAYLOAD, c, pay_pos, hold_seq, hold_len, 16'h0000);
                pay_pos = pay_pos + 16'd1;
                if (pay_pos >= hold_len) parse_st = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                crc_lo_hold = c;
                parse_st    = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                wire_crc = {c, crc_lo_hold};
                parse_st = PH_HUNT0;
                if (wire_crc == crc_acc) begin
                    good_cnt = good_cnt + 32'd1;
                    log_event(EV_GOOD, 8'h00, 16'h0000, hold_seq, hold_len, wire_crc);
                end else begin
                    bad_cnt = bad_cnt + 32'd1;
                    log_event(EV_BAD_CRC, 8'h00, 16'h0000, hold_seq, hold_len, wire_crc);
                end
            end
            default: begin
                parse_st = PH_HUNT0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    task automatic send_byte(input logic [7:0] data, input logic typed = 1'b0,
                             input result_t typed_want = '0);
        int unsigned gap;
        int          queued;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_rx_byte <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        queued = event_q.size();
        deframe_step(data);
        if (typed) begin
            if (event_q.size() != queued) void'(event_q.pop_back());
            event_q.push_back(typed_want);
        end
    endtask

    task automatic send_frame(input int unsigned len, input frame_fault_t fault);
        logic [7:0]  fr [$];
        logic [7:0]  b;
        logic [15:0] crc;
        int unsigned cut;
        crc = CRC_INIT;
        fr.push_back(mark_a);
        if (fault == FAULT_MARK) fr.push_back(mark_b ^ 8'($urandom_range(1, 255)));
        else fr.push_back(mark_b);
        for (int i = 0; i < 4 + ((len > len_limit) ? 0 : 1 + len); i++) begin
            case (i)
                2: b = len[7:0];
                3: b = len[15:8];
                default: b = 8'($urandom_range(0, 255));
            endcase
            fr.push_back(b);
            crc = crc16_ccitt_next(crc, b);
        end
        if (len <= len_limit) begin
            if (fault == FAULT_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
            fr.push_back(crc[7:0]);
            fr.push_back(crc[15:8]);
        end
        cut = (fault == FAULT_CUT) ? $urandom_range(3, fr.size() - 1) : fr.size();
        for (int i = 0; i < cut; i++) send_byte(fr[i]);
    endtask

    task automatic random_traffic(input int unsigned n_bytes);
        int unsigned stop_at;
        int unsigned len;
        int unsigned pick;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            len = $urandom_range(0, (len_limit < 12) ? len_limit : 12);
            case ($urandom_range(0, 9))
                0: if (len_limit <= 16) len = len_limit;
                1: begin
                    if (len_limit != 16'hFFFF) begin
                        len = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                          : $urandom_range(len_limit + 1, 65535);
                    end
                end
                default: ;
            endcase
            pick = $urandom_range(0, 19);
            if (pick < 14) send_frame(len, FAULT_NONE);
            else if (pick < 16) send_frame(len, FAULT_CRC);
            else if (pick == 16) send_frame(len, FAULT_MARK);
            else if (pick == 17 && len_limit <= 512) send_frame(len, FAULT_CUT);
            else repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (event_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_MARK_FIRST:  mark_a    = value[7:0];
            CFG_MARK_SECOND: mark_b    = value[7:0];
            CFG_MAX_LEN:     len_limit = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [7:0] first_mark, input logic [7:0] second_mark,
                             input logic [15:0] limit, input logic poke_unused);
        settle();
        write_reg(CFG_MARK_FIRST, {8'($urandom_range(0, 255)), first_mark});
        write_reg(CFG_MARK_SECOND, {8'($urandom_range(0, 255)), second_mark});
        write_reg(CFG_MAX_LEN, limit);
        if (poke_unused) write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (event_q.size() == 0) begin
                report_mismatch("unexpected item, event_kind", 32'(m_event_kind), 32'd0);
            end else begin
                head_event = event_q.pop_front();
                check_field("event_kind", 32'(m_event_kind), 32'(head_event.event_kind));
                check_field("payload_byte", 32'(m_payload_byte),
                            32'(head_event.payload_byte));
                check_field("payload_index", 32'(m_payload_index),
                            32'(head_event.payload_index));
                check_field("frame_version", 32'(m_frame_version),
                            32'(head_event.frame_version));
                check_field("frame_type", 32'(m_frame_type), 32'(head_event.frame_type));
                check_field("frame_sequence", 32'(m_frame_sequence),
                            32'(head_event.frame_sequence));
                check_field("frame_length", 32'(m_frame_length),
                            32'(head_event.frame_length));
                check_field("received_crc", 32'(m_received_crc),
                            32'(head_event.received_crc));
                check_field("good_frame_count", m_good_frame_count,
                            head_event.good_frame_count);
                check_field("bad_frame_count", m_bad_frame_count,
                            head_event.bad_frame_count);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : result_side
        logic [7:0] pat;
        wait (aresetn);
        repeat (300) begin
            @(posedge aclk);
            m_ready <= ($urandom_range(0, 2) != 0);
        end
        // A long hold-off fills the output register so that the input stalls.
        m_ready <= 1'b0;
        repeat (250) @(posedge aclk);
        forever begin
            case ($urandom_range(0, 9))
                0: begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(40, 160)) @(posedge aclk);
                end
                1, 2, 3: begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(20, 80)) @(posedge aclk);
                end
                default: begin
                    pat = 8'($urandom_range(1, 255));
                    repeat ($urandom_range(3, 10)) begin
                        for (int k = 0; k < 8; k++) begin
                            m_ready <= pat[k];
                            @(posedge aclk);
                        end
                    end
                end
            endcase
        end
    end

    initial begin : byte_side
        logic [7:0] data;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (DIRECTED[i]) begin
            case (DIRECTED[i].src)
                ROW_CRC_LO:     data = crc_acc[7:0];
                ROW_CRC_HI:     data = crc_acc[15:8];
                ROW_CRC_HI_BAD: data = ~crc_acc[15:8];
                default:        data = DIRECTED[i].data;
            endcase
            send_byte(data, DIRECTED[i].typed, DIRECTED[i].want);
        end
        send_frame(32'(len_limit), FAULT_NONE);
        random_traffic(250);
        configure(8'h3C, 8'hC3, 16'd5, 1'b0);
        random_traffic(300);
        configure(8'h00, 8'hFF, 16'd0, 1'b0);
        random_traffic(250);
        configure(8'hFF, 8'h00, 16'hFFFF, 1'b1);
        random_traffic(300);
        settle();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
